>>> rtl/rotary_encoder_setpoint_editor_top_assert.svh
// Assertion macros for the rotary encoder setpoint editor.
// Used by rotary_encoder_setpoint_editor_top; needs clk_i and rst_ni in scope.
`ifndef ROTARY_ENCODER_SETPOINT_EDITOR_TOP_ASSERT_SVH
`define ROTARY_ENCODER_SETPOINT_EDITOR_TOP_ASSERT_SVH

// Generic form: explicit clock and active-low reset.
`define RSE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Default form: the block's own clock and reset.
`define RSE_ASSERT(label, prop, msg) \
  `RSE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/rse_pkg.sv
// Package for the rotary encoder setpoint editor: widths, codes, reset values.
// No dependencies.
package rse_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int FREQ_BITS_DEF     = 24;

  localparam int PINS_W     = 2;
  localparam int STEP_W     = 2;
  localparam int POS_OUT_W  = 16;
  localparam int FREQ_OUT_W = 24;
  localparam int DUTY_W     = 10;
  localparam int TARGET_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDIT_TARGET = 3'd0,
    CFG_FREQ_MIN    = 3'd1,
    CFG_FREQ_MAX    = 3'd2,
    CFG_DUTY_MIN    = 3'd3,
    CFG_DUTY_MAX    = 3'd4
  } cfg_idx_e;

  // Edit target codes; codes 2 and 3 edit nothing
  localparam logic [TARGET_W-1:0] EDIT_FREQ = 2'd0;
  localparam logic [TARGET_W-1:0] EDIT_DUTY = 2'd1;

  // Pin states, pin_a in bit 1, pin_b in bit 0
  localparam logic [PINS_W-1:0] PINS_LOW  = 2'b00;
  localparam logic [PINS_W-1:0] PINS_B_HI = 2'b01;
  localparam logic [PINS_W-1:0] PINS_A_HI = 2'b10;
  localparam logic [PINS_W-1:0] PINS_HIGH = 2'b11;

  // Step codes
  localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
  localparam logic signed [STEP_W-1:0] STEP_UP   = 2'sb01;
  localparam logic signed [STEP_W-1:0] STEP_DOWN = 2'sb11;

  // Reset values
  localparam logic [FREQ_OUT_W-1:0] FREQ_MIN_RST  = 24'd1;
  localparam logic [FREQ_OUT_W-1:0] FREQ_MAX_RST  = 24'd10000000;
  localparam logic [DUTY_W-1:0]     DUTY_MIN_RST  = 10'd1;
  localparam logic [DUTY_W-1:0]     DUTY_MAX_RST  = 10'd1000;
  localparam logic [DUTY_W-1:0]     DUTY_VAL_RST  = 10'd501;
  localparam int                    FREQ_VAL_RST  = 2;

endpackage

>>> rtl/rotary_encoder_setpoint_editor_top.sv
// Rotary encoder setpoint editor: one registered result per accepted pin sample;
// 1 sample per cycle unless the result channel stalls. Decode, position count and
// saturating setpoint update sit between the state and result registers.
// A sample is taken whenever the result register is empty or being drained.
// Async active-low reset: pins high, detent disarmed, position 0, frequency 2,
// duty 501, limits and edit target to their defaults, result register empty.
`include "rotary_encoder_setpoint_editor_top_assert.svh"

module rotary_encoder_setpoint_editor_top #(
  parameter int POSITION_BITS = rse_pkg::POSITION_BITS_DEF,
  parameter int FREQ_BITS     = rse_pkg::FREQ_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rse_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rse_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // pin sample channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  pin_a_i,
  input  logic                                  pin_b_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rse_pkg::STEP_W-1:0]     step_o,
  output logic signed [rse_pkg::POS_OUT_W-1:0]  position_o,
  output logic [rse_pkg::FREQ_OUT_W-1:0]        frequency_setpoint_o,
  output logic [rse_pkg::DUTY_W-1:0]            duty_setpoint_o,
  output logic                                  value_changed_o
);
  import rse_pkg::*;

  localparam int FSW = FREQ_BITS + 2;
  localparam int DSW = DUTY_W + 2;

  // configuration registers
  logic [TARGET_W-1:0]   edit_target_q;
  logic [FREQ_OUT_W-1:0] freq_min_q, freq_max_q;
  logic [DUTY_W-1:0]     duty_min_q, duty_max_q;

  // decoder state
  logic [PINS_W-1:0]        last_q, last_d;
  logic                     armed_q, armed_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [FREQ_BITS-1:0]     freq_q, freq_d;
  logic [DUTY_W-1:0]        duty_q, duty_d;

  // result register
  logic                     out_valid_q;
  logic signed [STEP_W-1:0] step_q;
  logic [POS_OUT_W-1:0]     pos_out_q;
  logic [FREQ_OUT_W-1:0]    freq_out_q;
  logic [DUTY_W-1:0]        duty_out_q;
  logic                     changed_out_q;

  logic                     acc;
  logic [PINS_W-1:0]        pins_now;
  logic                     moved, inc, dec, arm, detent;
  logic signed [FSW-1:0]    f_sum, f_hi, f_lo, f_delta;
  logic signed [DSW-1:0]    d_sum, d_hi, d_lo, d_delta;
  logic [FREQ_BITS-1:0]     f_sat;
  logic [DUTY_W-1:0]        d_sat;
  logic [31:0]              pos_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_target_q <= EDIT_FREQ;
      freq_min_q    <= FREQ_MIN_RST;
      freq_max_q    <= FREQ_MAX_RST;
      duty_min_q    <= DUTY_MIN_RST;
      duty_max_q    <= DUTY_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_EDIT_TARGET: edit_target_q <= cfg_data_i[TARGET_W-1:0];
        CFG_FREQ_MIN:    freq_min_q    <= cfg_data_i[FREQ_OUT_W-1:0];
        CFG_FREQ_MAX:    freq_max_q    <= cfg_data_i[FREQ_OUT_W-1:0];
        CFG_DUTY_MIN:    duty_min_q    <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_MAX:    duty_max_q    <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // result register may refill in the cycle it drains
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  assign pins_now = {pin_a_i, pin_b_i};
  assign moved    = pins_now != last_q;
  assign inc      = moved && pins_now == PINS_HIGH && last_q == PINS_A_HI && armed_q;
  assign dec      = moved && pins_now == PINS_HIGH && last_q == PINS_B_HI && armed_q;
  assign arm      = moved && (pins_now == PINS_A_HI || pins_now == PINS_B_HI)
                    && last_q == PINS_LOW && !armed_q;
  assign detent   = inc || dec;

  always_comb begin
    last_d  = pins_now;
    armed_d = moved ? arm : armed_q;
    pos_d   = pos_q;
    if (inc) begin
      pos_d = pos_q + POSITION_BITS'(1);
    end else if (dec) begin
      pos_d = pos_q - POSITION_BITS'(1);
    end
  end

  // saturating frequency step: ceiling check wins over floor
  always_comb begin
    f_delta = dec ? '1 : FSW'(1);
    f_sum   = signed'(FSW'(freq_q)) + f_delta;
    f_hi    = signed'(FSW'(freq_max_q));
    f_lo    = signed'(FSW'(freq_min_q));
    if (f_sum >= f_hi) begin
      f_sat = f_hi[FREQ_BITS-1:0];
    end else if (f_sum <= f_lo) begin
      f_sat = f_lo[FREQ_BITS-1:0];
    end else begin
      f_sat = f_sum[FREQ_BITS-1:0];
    end
    freq_d = (detent && edit_target_q == EDIT_FREQ) ? f_sat : freq_q;
  end

  always_comb begin
    d_delta = dec ? '1 : DSW'(1);
    d_sum   = signed'(DSW'(duty_q)) + d_delta;
    d_hi    = signed'(DSW'(duty_max_q));
    d_lo    = signed'(DSW'(duty_min_q));
    if (d_sum >= d_hi) begin
      d_sat = d_hi[DUTY_W-1:0];
    end else if (d_sum <= d_lo) begin
      d_sat = d_lo[DUTY_W-1:0];
    end else begin
      d_sat = d_sum[DUTY_W-1:0];
    end
    duty_d = (detent && edit_target_q == EDIT_DUTY) ? d_sat : duty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= PINS_HIGH;
      armed_q <= 1'b0;
      pos_q   <= '0;
      freq_q  <= FREQ_BITS'(FREQ_VAL_RST);
      duty_q  <= DUTY_VAL_RST;
    end else if (acc) begin
      last_q  <= last_d;
      armed_q <= armed_d;
      pos_q   <= pos_d;
      freq_q  <= freq_d;
      duty_q  <= duty_d;
    end
  end

  // position counter zero-extends or truncates onto the 16-bit field
  assign pos_ext = 32'(pos_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      step_q        <= inc ? STEP_UP : (dec ? STEP_DOWN : STEP_NONE);
      pos_out_q     <= pos_ext[POS_OUT_W-1:0];
      freq_out_q    <= freq_d[FREQ_OUT_W-1:0];
      duty_out_q    <= duty_d;
      changed_out_q <= detent;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign step_o               = step_q;
  assign position_o           = signed'(pos_out_q);
  assign frequency_setpoint_o = freq_out_q;
  assign duty_setpoint_o      = duty_out_q;
  assign value_changed_o      = changed_out_q;

  `RSE_ASSERT(a_detent_needs_arm, acc && detent |-> armed_q, "detent counted while disarmed")
  `RSE_ASSERT(a_detent_disarms, acc && detent |=> !armed_q, "detent left the flag armed")
  `RSE_ASSERT(a_pos_up, acc && inc |=> (pos_q - $past(pos_q)) == POSITION_BITS'(1), "no inc")
  `RSE_ASSERT(a_stall_full, in_stall_o |-> out_valid_o, "input stalled with empty result register")
  `RSE_ASSERT(a_changed_step, out_valid_o |-> value_changed_o == (step_o != STEP_NONE), "flag")

endmodule

>>> tb/tb_rse_setpoint_tracker_pkg.sv
`timescale 1ns / 100ps
// Setpoint tracker class for the rotary encoder setpoint editor testbench:
// predicts each result from accepted pin samples and checks what comes out.
// Depends on rse_pkg for widths, register indexes, pin states and step codes.
package tb_rse_setpoint_tracker_pkg;
  import rse_pkg::*;

  // edit_target codes that leave both setpoints alone
  localparam logic [TARGET_W-1:0] EDIT_NONE     = 2'd2;
  localparam logic [TARGET_W-1:0] EDIT_NONE_ALT = 2'd3;

  typedef struct {
    logic signed [STEP_W-1:0]    step;
    logic signed [POS_OUT_W-1:0] position;
    logic [FREQ_OUT_W-1:0]       freq;
    logic [DUTY_W-1:0]           duty;
    logic                        changed;
  } setpoint_result_t;

  class setpoint_tracker;
    // register copies
    logic [TARGET_W-1:0]   edit_target = EDIT_FREQ;
    logic [FREQ_OUT_W-1:0] freq_min    = FREQ_MIN_RST;
    logic [FREQ_OUT_W-1:0] freq_max    = FREQ_MAX_RST;
    logic [DUTY_W-1:0]     duty_min    = DUTY_MIN_RST;
    logic [DUTY_W-1:0]     duty_max    = DUTY_MAX_RST;
    // decoder and setpoint state
    logic [PINS_W-1:0]     prev_pins      = PINS_HIGH;
    bit                    half_detent    = 1'b0;
    logic [POS_OUT_W-1:0]  position_count = '0;
    logic [FREQ_OUT_W-1:0] freq_now       = FREQ_OUT_W'(FREQ_VAL_RST);
    logic [DUTY_W-1:0]     duty_now       = DUTY_VAL_RST;

    setpoint_result_t due_results[$];
    int mismatches;
    int n_samples;
    int n_results;
    int n_up;
    int n_down;
    int n_clamped;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_EDIT_TARGET: edit_target = data[TARGET_W-1:0];
        CFG_FREQ_MIN:    freq_min    = data[FREQ_OUT_W-1:0];
        CFG_FREQ_MAX:    freq_max    = data[FREQ_OUT_W-1:0];
        CFG_DUTY_MIN:    duty_min    = data[DUTY_W-1:0];
        CFG_DUTY_MAX:    duty_max    = data[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // ceiling check first, so it wins when min > max
    function logic [FREQ_OUT_W-1:0] saturate_step(logic [FREQ_OUT_W-1:0] value,
                                                  logic signed [STEP_W-1:0] delta,
                                                  logic [FREQ_OUT_W-1:0] lo,
                                                  logic [FREQ_OUT_W-1:0] hi);
      longint sum;
      sum = longint'(value) + longint'(delta);
      if (sum >= longint'(hi)) begin
        if (sum > longint'(hi)) n_clamped++;
        return hi;
      end
      if (sum <= longint'(lo)) begin
        if (sum < longint'(lo)) n_clamped++;
        return lo;
      end
      return sum[FREQ_OUT_W-1:0];
    endfunction

    function void note_sample(logic pin_a, logic pin_b);
      logic [PINS_W-1:0]        pins;
      logic signed [STEP_W-1:0] delta;
      setpoint_result_t         want;
      pins  = {pin_a, pin_b};
      delta = STEP_NONE;
      n_samples++;
      if (pins != prev_pins) begin
        if (pins == PINS_HIGH && prev_pins == PINS_A_HI && half_detent) begin
          delta = STEP_UP;
          half_detent = 1'b0;
        end else if (pins == PINS_HIGH && prev_pins == PINS_B_HI && half_detent) begin
          delta = STEP_DOWN;
          half_detent = 1'b0;
        end else if ((pins == PINS_A_HI || pins == PINS_B_HI) && prev_pins == PINS_LOW &&
                     !half_detent) begin
          half_detent = 1'b1;
        end else begin
          half_detent = 1'b0;
        end
        prev_pins = pins;
      end
      if (delta != STEP_NONE) begin
        if (delta == STEP_UP) begin
          position_count++;
          n_up++;
        end else begin
          position_count--;
          n_down++;
        end
        if (edit_target == EDIT_FREQ)
          freq_now = saturate_step(freq_now, delta, freq_min, freq_max);
        else if (edit_target == EDIT_DUTY)
          duty_now = DUTY_W'(saturate_step(FREQ_OUT_W'(duty_now), delta,
                                           FREQ_OUT_W'(duty_min), FREQ_OUT_W'(duty_max)));
      end
      want.step     = delta;
      want.position = position_count;
      want.freq     = freq_now;
      want.duty     = duty_now;
      want.changed  = (delta != STEP_NONE);
      due_results.push_back(want);
    endfunction

    function void check_result(logic signed [STEP_W-1:0] step, logic signed [POS_OUT_W-1:0] pos,
                               logic [FREQ_OUT_W-1:0] freq, logic [DUTY_W-1:0] duty,
                               logic changed);
      setpoint_result_t want;
      n_results++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no sample outstanding", n_results);
        return;
      end
      want = due_results.pop_front();
      if (step !== want.step || pos !== want.position || freq !== want.freq ||
          duty !== want.duty || changed !== want.changed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch (exp/got): step %0d/%0d pos %0d/%0d ",
                   n_results, want.step, step, want.position, pos,
                   "freq %0d/%0d duty %0d/%0d changed %0b/%0b",
                   want.freq, freq, want.duty, duty, want.changed, changed);
      end
    endfunction

    function int results_due();
      return due_results.size();
    endfunction
  endclass

endpackage

>>> tb/tb_rotary_encoder_setpoint_editor_top.sv
`timescale 1ns / 100ps
// Testbench for rotary_encoder_setpoint_editor_top: directed and random pin
// sequences under several limit settings, random stalls on both channels.
// Depends on rse_pkg and tb_rse_setpoint_tracker_pkg.
module tb_rotary_encoder_setpoint_editor_top;
  import rse_pkg::*;
  import tb_rse_setpoint_tracker_pkg::*;

  localparam int    PHASE_SAMPLES   = 80;
  localparam int    HOLD_OFF_CYCLES = 60;
  localparam int    DRAIN_CYCLES    = 3;
  localparam time   TIMEOUT_NS      = 2_000_000;
  localparam longint FREQ_TOP       = (longint'(1) << FREQ_OUT_W) - 1;
  localparam longint DUTY_TOP       = (longint'(1) << DUTY_W) - 1;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          pin_a_i;
  logic                          pin_b_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [STEP_W-1:0]      step_o;
  logic signed [POS_OUT_W-1:0]   position_o;
  logic [FREQ_OUT_W-1:0]         frequency_setpoint_o;
  logic [DUTY_W-1:0]             duty_setpoint_o;
  logic                          value_changed_o;

  setpoint_tracker sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_off_reqs = 0;
  int hold_off_done = 0;
  int n_settings = 0;

  // rest, two downs, one up, then double-pin changes
  logic [PINS_W-1:0] directed_pins [20] = '{
    PINS_HIGH, PINS_HIGH,
    PINS_A_HI, PINS_LOW, PINS_B_HI, PINS_HIGH,
    PINS_A_HI, PINS_LOW, PINS_B_HI, PINS_HIGH,
    PINS_B_HI, PINS_LOW, PINS_A_HI, PINS_HIGH,
    PINS_LOW, PINS_HIGH,
    PINS_LOW, PINS_A_HI, PINS_B_HI, PINS_HIGH
  };

  rotary_encoder_setpoint_editor_top uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .pin_a_i              (pin_a_i),
    .pin_b_i              (pin_b_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .step_o               (step_o),
    .position_o           (position_o),
    .frequency_setpoint_o (frequency_setpoint_o),
    .duty_setpoint_o      (duty_setpoint_o),
    .value_changed_o      (value_changed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // result side: stall driver with an occasional long hold-off
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_done < hold_off_reqs) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done++;
      end
      out_stall_i <= rx_idle_on && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(step_o, position_o, frequency_setpoint_o, duty_setpoint_o,
                      value_changed_o);
  end

  function automatic logic [FREQ_OUT_W-1:0] offset_clip(longint cur, int offset, longint top);
    longint v;
    v = cur + offset;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v[FREQ_OUT_W-1:0];
  endfunction

  task automatic send_pins(input logic [PINS_W-1:0] pins);
    while (tx_idle_on && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_a_i    <= pins[1];
    pin_b_i    <= pins[0];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(pins[1], pins[0]);
  endtask

  // one detent sequence with contact dwell, a broken one, or a lone random sample
  task automatic send_burst(inout int sent);
    logic [PINS_W-1:0] pins_seq [4];
    int kind;
    int n_rep;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_pins(PINS_W'($urandom));
      sent++;
    end else begin
      if ($urandom_range(1))
        pins_seq = '{PINS_B_HI, PINS_LOW, PINS_A_HI, PINS_HIGH};
      else
        pins_seq = '{PINS_A_HI, PINS_LOW, PINS_B_HI, PINS_HIGH};
      if (kind < 30) pins_seq[$urandom_range(3)] = PINS_W'($urandom);
      foreach (pins_seq[i]) begin
        n_rep = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n_rep) begin
          send_pins(pins_seq[i]);
          sent++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.results_due() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // junk in the upper data bits checks the masking; unused indexes must be ignored
  task automatic program_regs(input logic [TARGET_W-1:0] target,
                              input logic [FREQ_OUT_W-1:0] fmin, fmax,
                              input logic [DUTY_W-1:0] dmin, dmax);
    write_reg(CFG_EDIT_TARGET, {(CFG_DATA_W-TARGET_W)'($urandom), target});
    write_reg(CFG_FREQ_MIN, fmin);
    write_reg(CFG_FREQ_MAX, fmax);
    write_reg(CFG_DUTY_MIN, {(CFG_DATA_W-DUTY_W)'($urandom), dmin});
    write_reg(CFG_DUTY_MAX, {(CFG_DATA_W-DUTY_W)'($urandom), dmax});
    for (int idx = int'(CFG_DUTY_MAX) + 1; idx < 2**CFG_IDX_W; idx++)
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int sent;
    bit paused;
    longint cur_f;
    longint cur_d;
    logic [FREQ_OUT_W-1:0] same_f;
    logic [DUTY_W-1:0] same_d;
    sb = new;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    pin_a_i     <= 1'b1;
    pin_b_i     <= 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_pins[i]) send_pins(directed_pins[i]);

    for (int phase = 1; phase <= 8; phase++) begin
      wait_drained();
      cur_f = longint'(sb.freq_now);
      cur_d = longint'(sb.duty_now);
      tx_idle_on = (phase != 6);
      rx_idle_on = (phase != 6);
      case (phase)
        1: program_regs(EDIT_FREQ, '0, '1, '0, '1);
        2: program_regs(EDIT_DUTY, FREQ_OUT_W'($urandom_range(1, 10000000)),
                        FREQ_OUT_W'($urandom_range(1, 10000000)),
                        DUTY_W'(offset_clip(cur_d, -2, DUTY_TOP)),
                        DUTY_W'(offset_clip(cur_d, 2, DUTY_TOP)));
        3: program_regs(EDIT_FREQ, offset_clip(cur_f, -2, FREQ_TOP),
                        offset_clip(cur_f, 2, FREQ_TOP), DUTY_MIN_RST, DUTY_MAX_RST);
        // limits move under a setpoint that nothing edits
        4: program_regs(EDIT_NONE, FREQ_OUT_W'($urandom), FREQ_OUT_W'($urandom),
                        DUTY_W'($urandom), DUTY_W'($urandom));
        // min above max: frequency limits here, duty limits in phase 6
        5: program_regs(EDIT_FREQ, offset_clip(cur_f, 10, FREQ_TOP),
                        offset_clip(cur_f, 4, FREQ_TOP), DUTY_W'($urandom), DUTY_W'($urandom));
        6: program_regs(EDIT_DUTY, FREQ_MIN_RST, FREQ_MAX_RST,
                        DUTY_W'(offset_clip(cur_d, 8, DUTY_TOP)),
                        DUTY_W'(offset_clip(cur_d, 3, DUTY_TOP)));
        7: begin
          same_f = FREQ_OUT_W'($urandom);
          same_d = DUTY_W'($urandom);
          program_regs(EDIT_NONE_ALT, same_f, same_f, same_d, same_d);
        end
        default: program_regs(EDIT_FREQ, FREQ_OUT_W'(cur_f), FREQ_OUT_W'(cur_f),
                              DUTY_MIN_RST, DUTY_MAX_RST);
      endcase
      if (phase == 3) hold_off_reqs++;
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_SAMPLES) begin
        if (phase == 5 && !paused && sent >= PHASE_SAMPLES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        send_burst(sent);
      end
    end

    wait_drained();
    $display("Covered %0d pin samples over %0d register settings: %0d detents up, %0d down,",
             sb.n_samples, n_settings, sb.n_up, sb.n_down);
    $display("%0d setpoint updates clamped at a limit, %0d results checked, %0d mismatches.",
             sb.n_clamped, sb.n_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.results_due() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
